>>> hw/rtl/ctac_pkg.sv
// Shared constants, types and calendar functions of the tick and alarm calculator.
`default_nettype none
package ctac_pkg;

  localparam int unsigned SsBits   = 10;
  localparam logic [SsBits-1:0] SsMax = {SsBits{1'b1}};
  localparam int unsigned SecsW    = 32 - SsBits;
  localparam logic [16:0] SecPerDay  = 17'd86400;
  localparam logic [11:0] SecPerHour = 12'd3600;
  localparam logic [5:0]  SecPerMin  = 6'd60;
  localparam logic [31:0] CorrNorm   = 32'h0099AAA0;
  localparam logic [31:0] CorrLeap   = 32'h00445550;

  // Reciprocal estimates; each undershoots by at most one.
  localparam logic [9:0] RecipDay  = 10'd776;  // 2^19 / 675
  localparam logic [8:0] RecipHour = 9'd291;   // 2^16 / 225
  localparam logic [8:0] RecipMin  = 9'd273;   // 2^12 / 15

  localparam int unsigned StepW    = 4;
  localparam logic [StepW-1:0] LastStep = 4'd13;

  localparam logic [1:0] OpCapture = 2'd0;
  localparam logic [1:0] OpAlarm   = 2'd1;
  localparam logic [1:0] OpElapsed = 2'd2;

  typedef struct packed {
    logic load;
    logic write;
  } ctac_cmd_t;

  // Saturate month number to table index 0..11.
  function automatic logic [3:0] month_index(input logic [3:0] month);
    logic [3:0] idx;
    if (month == 4'd0) idx = 4'd0;
    else if (month > 4'd12) idx = 4'd11;
    else idx = month - 4'd1;
    return idx;
  endfunction

  // Days before the first of the month within the year.
  function automatic logic [8:0] month_offset(input logic [3:0] mi, input logic leap);
    logic [31:0] corr;
    logic [31:0] base;
    logic [1:0]  fix;
    corr = leap ? CorrLeap : CorrNorm;
    base = (32'(mi) * 32'd61 + 32'd1) >> 1;
    fix  = 2'(corr >> (32'(mi) << 1));
    return 9'(base - 32'(fix));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mi, input logic leap);
    logic [4:0] len;
    case (mi)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ctac_ctrl.sv
// Controller: accepts a word, counts datapath steps, owns the result valid flag.
`default_nettype none
module ctac_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ctac_pkg::ctac_cmd_t     cmd_o
);
  import ctac_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StBusy = 1'b1;

  logic             state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;

  // Decode commands
  always_comb begin
    cmd_o.load  = (state_q == StIdle) && in_valid_i;
    cmd_o.write = (state_q == StBusy) && (step_q == LastStep) &&
                  (!out_valid_q || out_ready_i);
  end

  // Advance state and step count
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StBusy;
          step_d  = '0;
        end
      end
      StBusy: begin
        if (step_q != LastStep) begin
          step_d = step_q + StepW'(1);
        end else if (cmd_o.write) begin
          state_d     = StIdle;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  a_write_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.write |-> (state_q == StBusy) && (step_q == LastStep))
    else $error("write outside last step");
  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == StBusy) && (step_q == '0))
    else $error("load did not start a run");
  a_valid_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.write))
    else $error("result valid without write");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.write |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

>>> hw/rtl/ctac_dp.sv
// Datapath: tick count, elapsed ticks, alarm time split and carry chain, reference store.
`default_nettype none
module ctac_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ctac_pkg::ctac_cmd_t cmd_i,
  input  wire logic [1:0]          operation_i,
  input  wire logic [6:0]          year_i,
  input  wire logic [3:0]          month_i,
  input  wire logic [4:0]          day_i,
  input  wire logic [4:0]          hours_i,
  input  wire logic [5:0]          minutes_i,
  input  wire logic [5:0]          seconds_i,
  input  wire logic [9:0]          subseconds_i,
  input  wire logic [31:0]         timeout_ticks_i,
  output logic [31:0]              tick_value_o,
  output logic [4:0]               alarm_day_o,
  output logic [4:0]               alarm_hours_o,
  output logic [5:0]               alarm_minutes_o,
  output logic [5:0]               alarm_seconds_o,
  output logic [9:0]               alarm_subseconds_o
);
  import ctac_pkg::*;

  // Latched word
  logic [1:0]  op_q;
  logic [6:0]  year_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q, hours_q;
  logic [5:0]  min_q, sec_q;
  logic [9:0]  ss_q;
  logic [31:0] tmo_q;

  // Reference
  logic [31:0] ref_ticks_q;
  logic [6:0]  ref_year_q;
  logic [3:0]  ref_month_q;
  logic [4:0]  ref_day_q, ref_hours_q;
  logic [5:0]  ref_min_q, ref_sec_q;
  logic [9:0]  ref_ss_q;

  // Tick path
  logic [31:0] days_q, t_q, tick_q, diff_q;
  logic [16:0] sod_q;

  // Alarm path
  logic [SecsW-1:0] secs;
  logic [5:0]  q1e_q, q1_q;
  logic [22:0] p1_q;
  logic [16:0] r1_q;
  logic [4:0]  q2e_q, q2_q;
  logic [16:0] p2_q;
  logic [11:0] r2_q;
  logic [5:0]  q3e_q, q3_q;
  logic [11:0] p3_q;
  logic [5:0]  r3_q;
  logic        ssc_q;
  logic [SsBits-1:0] ass_q;
  logic [5:0]  as_q, am_q;
  logic [1:0]  cs_q, cm_q, ch_q;
  logic [4:0]  ah_q, ad_q;

  // Combinational helpers
  logic [31:0] yr_days, t_d;
  logic [3:0]  mi, ref_mi;
  logic [24:0] n1m;
  logic [21:0] r1raw;
  logic [21:0] n2m;
  logic [12:0] r2raw;
  logic [18:0] n3m;
  logic [6:0]  r3raw;
  logic [SsBits:0] ss_sum;
  logic [6:0]  as_raw, am_raw, ad_raw;
  logic [5:0]  ah_raw;
  logic [4:0]  mlen;
  logic [5:0]  mlen2;
  logic [49:0] t_prod;

  assign secs    = tmo_q[31:SsBits];
  assign mi      = month_index(month_q);
  assign ref_mi  = month_index(ref_month_q);
  assign yr_days = (32'(year_q) * 32'd1461 + 32'd3) >> 2;
  assign t_prod  = days_q * SecPerDay;
  assign t_d     = t_prod[31:0] + 32'(sod_q);
  assign n1m     = 25'(secs >> 7) * 25'(RecipDay);
  assign r1raw   = 22'(secs) - 22'(p1_q);
  assign n2m     = 22'(r1_q >> 4) * 22'(RecipHour);
  assign r2raw   = 13'(r1_q - p2_q);
  assign n3m     = 19'(r2_q >> 2) * 19'(RecipMin);
  assign r3raw   = 7'(r2_q - p3_q);
  assign ss_sum  = (SsBits+1)'(SsMax - ref_ss_q[SsBits-1:0]) + (SsBits+1)'(tmo_q[SsBits-1:0]);
  assign as_raw  = 7'(ref_sec_q) + 7'(r3_q) + 7'(ssc_q);
  assign am_raw  = 7'(ref_min_q) + 7'(q3_q) + 7'(cs_q);
  assign ah_raw  = 6'(ref_hours_q) + 6'(q2_q) + 6'(cm_q);
  assign ad_raw  = 7'(ref_day_q) + 7'(q1_q) + 7'(ch_q);
  assign mlen    = month_len(ref_mi, ref_year_q[1:0] == 2'd0);
  assign mlen2   = {mlen, 1'b0};

  // Latch the accepted word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      year_q  <= year_i;
      month_q <= month_i;
      day_q   <= day_i;
      hours_q <= hours_i;
      min_q   <= minutes_i;
      sec_q   <= seconds_i;
      ss_q    <= subseconds_i;
      tmo_q   <= timeout_ticks_i;
    end
  end

  // Run the step chain; values settle before the last step
  always_ff @(posedge clk_i) begin
    // tick count
    days_q <= yr_days + 32'(month_offset(mi, year_q[1:0] == 2'd0)) + 32'(day_q) - 32'd1;
    sod_q  <= 17'(sec_q) + 17'(min_q) * 17'(SecPerMin) + 17'(hours_q) * 17'(SecPerHour);
    t_q    <= t_d;
    tick_q <= (t_q << SsBits) + 32'(SsMax - ss_q[SsBits-1:0]);
    diff_q <= tick_q - ref_ticks_q;
    // days, then hours, then minutes of the timeout
    q1e_q <= 6'(n1m >> 19);
    p1_q  <= 23'(q1e_q) * 23'(SecPerDay);
    if (r1raw >= 22'(SecPerDay)) begin
      r1_q <= 17'(r1raw - 22'(SecPerDay));
      q1_q <= q1e_q + 6'd1;
    end else begin
      r1_q <= 17'(r1raw);
      q1_q <= q1e_q;
    end
    q2e_q <= 5'(n2m >> 16);
    p2_q  <= 17'(q2e_q) * 17'(SecPerHour);
    if (r2raw >= 13'(SecPerHour)) begin
      r2_q <= 12'(r2raw - 13'(SecPerHour));
      q2_q <= q2e_q + 5'd1;
    end else begin
      r2_q <= 12'(r2raw);
      q2_q <= q2e_q;
    end
    q3e_q <= 6'(n3m >> 12);
    p3_q  <= 12'(q3e_q) * 12'(SecPerMin);
    if (r3raw >= 7'(SecPerMin)) begin
      r3_q <= 6'(r3raw - 7'(SecPerMin));
      q3_q <= q3e_q + 6'd1;
    end else begin
      r3_q <= 6'(r3raw);
      q3_q <= q3e_q;
    end
    // subsecond carry
    ssc_q <= ss_sum[SsBits];
    ass_q <= ss_sum[SsBits-1:0];
    // seconds, minutes, hours carry
    if (as_raw >= 7'd120) begin
      as_q <= 6'(as_raw - 7'd120); cs_q <= 2'd2;
    end else if (as_raw >= 7'd60) begin
      as_q <= 6'(as_raw - 7'd60);  cs_q <= 2'd1;
    end else begin
      as_q <= 6'(as_raw);          cs_q <= 2'd0;
    end
    if (am_raw >= 7'd120) begin
      am_q <= 6'(am_raw - 7'd120); cm_q <= 2'd2;
    end else if (am_raw >= 7'd60) begin
      am_q <= 6'(am_raw - 7'd60);  cm_q <= 2'd1;
    end else begin
      am_q <= 6'(am_raw);          cm_q <= 2'd0;
    end
    if (ah_raw >= 6'd48) begin
      ah_q <= 5'(ah_raw - 6'd48); ch_q <= 2'd2;
    end else if (ah_raw >= 6'd24) begin
      ah_q <= 5'(ah_raw - 6'd24); ch_q <= 2'd1;
    end else begin
      ah_q <= 5'(ah_raw);         ch_q <= 2'd0;
    end
    // month wrap, may give day zero
    if (ad_raw > 7'(mlen)) begin
      if (ad_raw >= 7'(mlen2)) ad_q <= 5'(ad_raw - 7'(mlen2));
      else                     ad_q <= 5'(ad_raw - 7'(mlen));
    end else begin
      ad_q <= 5'(ad_raw);
    end
  end

  // Hold the reference; capture on a finished capture word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_ticks_q <= '0;
      ref_year_q  <= '0;
      ref_month_q <= 4'd1;
      ref_day_q   <= 5'd1;
      ref_hours_q <= '0;
      ref_min_q   <= '0;
      ref_sec_q   <= '0;
      ref_ss_q    <= '1;
    end else if (cmd_i.write && (op_q == OpCapture)) begin
      ref_ticks_q <= tick_q;
      ref_year_q  <= year_q;
      ref_month_q <= month_q;
      ref_day_q   <= day_q;
      ref_hours_q <= hours_q;
      ref_min_q   <= min_q;
      ref_sec_q   <= sec_q;
      ref_ss_q    <= ss_q;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      case (op_q)
        OpCapture: begin
          tick_value_o       <= tick_q;
          alarm_day_o        <= '0;
          alarm_hours_o      <= '0;
          alarm_minutes_o    <= '0;
          alarm_seconds_o    <= '0;
          alarm_subseconds_o <= '0;
        end
        OpElapsed: begin
          tick_value_o       <= diff_q;
          alarm_day_o        <= '0;
          alarm_hours_o      <= '0;
          alarm_minutes_o    <= '0;
          alarm_seconds_o    <= '0;
          alarm_subseconds_o <= '0;
        end
        OpAlarm: begin
          tick_value_o       <= '0;
          alarm_day_o        <= ad_q;
          alarm_hours_o      <= ah_q;
          alarm_minutes_o    <= am_q;
          alarm_seconds_o    <= as_q;
          alarm_subseconds_o <= 10'(SsMax - ass_q);
        end
        default: begin
          tick_value_o       <= '0;
          alarm_day_o        <= '0;
          alarm_hours_o      <= '0;
          alarm_minutes_o    <= '0;
          alarm_seconds_o    <= '0;
          alarm_subseconds_o <= '0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/calendar_tick_alarm_calculator.sv
// Top level of the calendar tick and alarm calculator.
// Takes one word at a time and returns one result word for each. Between a word's acceptance
// and its result being offered, the alarm time split walks three constant divides
// (day, hour, minute), each as a reciprocal estimate, a product and a one-step
// correction, followed by the second, minute, hour and day carries. A new word is taken
// the cycle after the previous result is loaded, even while that result still waits.
`default_nettype none
module calendar_tick_alarm_calculator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [6:0]  year_i,
  input  wire logic [3:0]  month_i,
  input  wire logic [4:0]  day_i,
  input  wire logic [4:0]  hours_i,
  input  wire logic [5:0]  minutes_i,
  input  wire logic [5:0]  seconds_i,
  input  wire logic [9:0]  subseconds_i,
  input  wire logic [31:0] timeout_ticks_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      tick_value_o,
  output logic [4:0]       alarm_day_o,
  output logic [4:0]       alarm_hours_o,
  output logic [5:0]       alarm_minutes_o,
  output logic [5:0]       alarm_seconds_o,
  output logic [9:0]       alarm_subseconds_o
);
  import ctac_pkg::*;

  ctac_cmd_t cmd;

  // Sequence the run
  ctac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Compute the result
  ctac_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .operation_i        (operation_i),
    .year_i             (year_i),
    .month_i            (month_i),
    .day_i              (day_i),
    .hours_i            (hours_i),
    .minutes_i          (minutes_i),
    .seconds_i          (seconds_i),
    .subseconds_i       (subseconds_i),
    .timeout_ticks_i    (timeout_ticks_i),
    .tick_value_o       (tick_value_o),
    .alarm_day_o        (alarm_day_o),
    .alarm_hours_o      (alarm_hours_o),
    .alarm_minutes_o    (alarm_minutes_o),
    .alarm_seconds_o    (alarm_seconds_o),
    .alarm_subseconds_o (alarm_subseconds_o)
  );

endmodule
`default_nettype wire
